// ===== design/pfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pattern file pixel decoder - shared definitions
// Result kinds, error codes, header byte positions and the output payload.
// ----------------------------------------------------------------------------
package pfpd_pkg;

  localparam int unsigned MaxDim       = 4096;
  localparam int unsigned DimW         = 13;
  localparam int unsigned CoordW       = 12;
  localparam int unsigned HeaderBytes  = 24;

  // last byte of each big-endian header word
  localparam int unsigned LenByte      = 3;
  localparam int unsigned WidthByte    = 11;
  localparam int unsigned HeightByte   = 15;
  localparam int unsigned ChanByte     = 19;
  localparam int unsigned HeaderLast   = 23;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_SHORT_HEADER = 3'd0,
    ERR_UNTERMINATED = 3'd1,
    ERR_ZERO_SIZE    = 3'd2,
    ERR_TOO_LARGE    = 3'd3,
    ERR_BAD_CHANNELS = 3'd4,
    ERR_TRUNCATED    = 3'd5
  } err_t;

  // packed from the msb down; red lands in the lowest bits of tdata
  typedef struct packed {
    logic [2:0]        error_code;
    logic [DimW-1:0]   image_height;
    logic [DimW-1:0]   image_width;
    logic [2:0]        channels;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] column;
    logic [7:0]        alpha;
    logic [7:0]        blue;
    logic [7:0]        green;
    logic [7:0]        red;
  } result_t;

  localparam int unsigned OutDataW = $bits(result_t);

endpackage

// ===== design/pattern_file_pixel_decoder.sv =====
// ----------------------------------------------------------------------------
// Pattern file pixel decoder
// Parses a pattern file header and name, then emits RGBA pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* carries one file byte per request in s_tdata, with
//   s_tlast on the final byte of the file. After that byte the decoder rearms
//   for a new file. Master channel m_* carries at most one result per byte:
//   m_tuser is the kind (pixel, header accepted, error), m_tlast marks the
//   final pixel of the image, m_tdata carries the payload; fields that do not
//   apply to the kind are zero.
//   Throughput is one byte per cycle while s_tready is high: each byte goes
//   through one pass of parse logic into a result register, from which the
//   result is shown on m_*.
//   When the receiver stalls, a second result slot takes one more result;
//   s_tready drops only while that slot is full.
//   Reset (rst, synchronous) returns the parser to the start of a header and
//   empties both result slots.
// ----------------------------------------------------------------------------
module pattern_file_pixel_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // data_byte
  input  logic                          s_tlast,   // end_of_file
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // red, green, blue, alpha, column, row, channels, image_width,
  // image_height, error_code
  output logic [pfpd_pkg::OutDataW-1:0] m_tdata,
  output logic [1:0]                    m_tuser,   // kind
  output logic                          m_tlast    // last_pixel
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  localparam int unsigned DW = pfpd_pkg::DimW;
  localparam int unsigned CW = pfpd_pkg::CoordW;

  // parser state
  phase_t           phase, phase_next;
  logic [31:0]      byte_index, byte_index_next;
  logic [23:0]      word_shift, word_shift_next;
  logic [31:0]      header_length, header_length_next;
  logic [DW-1:0]    stored_width, stored_width_next;
  logic [DW-1:0]    stored_height, stored_height_next;
  logic [2:0]       stored_channels, stored_channels_next;
  logic             dim_zero, dim_zero_next;
  logic             dim_big, dim_big_next;
  logic             chan_bad, chan_bad_next;
  logic [CW-1:0]    column_count, column_count_next;
  logic [CW-1:0]    row_count, row_count_next;
  logic [1:0]       channel_index, channel_index_next;
  logic [23:0]      pixel_bytes, pixel_bytes_next;

  // result slots
  logic              out_valid, skid_valid;
  pfpd_pkg::result_t out_res, skid_res;
  pfpd_pkg::kind_t   out_kind, skid_kind;
  logic              out_last, skid_last;

  // one pass results
  logic              push;
  pfpd_pkg::result_t res;
  pfpd_pkg::kind_t   res_kind;
  logic              res_last;

  logic              accept, eof, pop;
  logic [7:0]        b;
  logic [31:0]       word;
  logic [23:0]       bytes_new;
  logic [1:0]        ci_inc;
  logic              pix_done, col_last, row_last, pix_last;
  logic [DW-1:0]     width_m1, height_m1;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;
  assign eof      = s_tlast;
  assign b        = s_tdata;
  assign word     = {word_shift, b};

  assign width_m1  = stored_width - DW'(1);
  assign height_m1 = stored_height - DW'(1);
  assign col_last  = column_count == width_m1[CW-1:0];
  assign row_last  = row_count == height_m1[CW-1:0];
  assign pix_last  = col_last && row_last;
  assign ci_inc    = channel_index + 2'd1;
  assign pix_done  = ci_inc == stored_channels[1:0];

  always_comb begin
    bytes_new = pixel_bytes;
    case (channel_index)
      2'd0:    bytes_new[7:0]   = b;
      2'd1:    bytes_new[15:8]  = b;
      2'd2:    bytes_new[23:16] = b;
      default: bytes_new = pixel_bytes;  // fourth byte is used directly
    endcase
  end

  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    word_shift_next      = word_shift;
    header_length_next   = header_length;
    stored_width_next    = stored_width;
    stored_height_next   = stored_height;
    stored_channels_next = stored_channels;
    dim_zero_next        = dim_zero;
    dim_big_next         = dim_big;
    chan_bad_next        = chan_bad;
    column_count_next    = column_count;
    row_count_next       = row_count;
    channel_index_next   = channel_index;
    pixel_bytes_next     = pixel_bytes;
    push                 = 1'b0;
    res                  = '0;
    res_kind             = pfpd_pkg::KIND_PIXEL;
    res_last             = 1'b0;

    case (phase)
      PH_HEADER: begin
        word_shift_next = word[23:0];
        byte_index_next = byte_index + 32'd1;
        if (byte_index == 32'(pfpd_pkg::LenByte)) begin
          header_length_next = word;
        end
        if (byte_index == 32'(pfpd_pkg::WidthByte)) begin
          stored_width_next = word[DW-1:0];
          dim_zero_next     = word == 32'd0;
          dim_big_next      = word > 32'(pfpd_pkg::MaxDim);
        end
        if (byte_index == 32'(pfpd_pkg::HeightByte)) begin
          stored_height_next = word[DW-1:0];
          dim_zero_next      = dim_zero || (word == 32'd0);
          dim_big_next       = dim_big || (word > 32'(pfpd_pkg::MaxDim));
        end
        if (byte_index == 32'(pfpd_pkg::ChanByte)) begin
          stored_channels_next = word[2:0];
          chan_bad_next        = (word == 32'd0) || (word > 32'd4);
        end
        if (byte_index == 32'(pfpd_pkg::HeaderLast)) begin
          if (header_length < 32'(pfpd_pkg::HeaderBytes)) begin
            push = 1'b1;
            res.error_code = pfpd_pkg::ERR_SHORT_HEADER;
          end else if (header_length == 32'(pfpd_pkg::HeaderBytes)) begin
            // empty name has no terminator
            push = 1'b1;
            res.error_code = pfpd_pkg::ERR_UNTERMINATED;
          end else begin
            phase_next = PH_NAME;
          end
        end
        if (eof && !push) begin
          push = 1'b1;
          res.error_code = pfpd_pkg::ERR_SHORT_HEADER;
        end
        if (push) begin
          res_kind   = pfpd_pkg::KIND_ERROR;
          phase_next = PH_DONE;
        end
      end

      PH_NAME: begin
        byte_index_next = byte_index + 32'd1;
        if (byte_index == header_length - 32'd1) begin
          push = 1'b1;
          res_kind = pfpd_pkg::KIND_ERROR;
          phase_next = PH_DONE;
          if (b != 8'd0) begin
            res.error_code = pfpd_pkg::ERR_UNTERMINATED;
          end else if (dim_zero) begin
            res.error_code = pfpd_pkg::ERR_ZERO_SIZE;
          end else if (dim_big) begin
            res.error_code = pfpd_pkg::ERR_TOO_LARGE;
          end else if (chan_bad) begin
            res.error_code = pfpd_pkg::ERR_BAD_CHANNELS;
          end else if (eof) begin
            res.error_code = pfpd_pkg::ERR_TRUNCATED;
          end else begin
            res_kind           = pfpd_pkg::KIND_HEADER;
            res.channels       = stored_channels;
            res.image_width    = stored_width;
            res.image_height   = stored_height;
            phase_next         = PH_PIXELS;
            column_count_next  = '0;
            row_count_next     = '0;
            channel_index_next = '0;
            pixel_bytes_next   = '0;
          end
        end else if (eof) begin
          push           = 1'b1;
          res_kind       = pfpd_pkg::KIND_ERROR;
          res.error_code = pfpd_pkg::ERR_SHORT_HEADER;
          phase_next     = PH_DONE;
        end
      end

      PH_PIXELS: begin
        channel_index_next = ci_inc;
        pixel_bytes_next   = bytes_new;
        if (pix_done) begin
          push               = 1'b1;
          channel_index_next = '0;
          pixel_bytes_next   = '0;
          if (eof && !pix_last) begin
            res_kind       = pfpd_pkg::KIND_ERROR;
            res.error_code = pfpd_pkg::ERR_TRUNCATED;
            phase_next     = PH_DONE;
          end else begin
            res.red    = bytes_new[7:0];
            res.column = column_count;
            res.row    = row_count;
            res_last   = pix_last;
            case (stored_channels)
              3'd1: begin
                res.green = bytes_new[7:0];
                res.blue  = bytes_new[7:0];
                res.alpha = 8'hFF;
              end
              3'd2: begin
                res.green = bytes_new[7:0];
                res.blue  = bytes_new[7:0];
                res.alpha = bytes_new[15:8];
              end
              3'd3: begin
                res.green = bytes_new[15:8];
                res.blue  = bytes_new[23:16];
                res.alpha = 8'hFF;
              end
              default: begin
                res.green = bytes_new[15:8];
                res.blue  = bytes_new[23:16];
                res.alpha = b;
              end
            endcase
            if (pix_last) begin
              phase_next = PH_DONE;
            end else if (col_last) begin
              column_count_next = '0;
              row_count_next    = row_count + CW'(1);
            end else begin
              column_count_next = column_count + CW'(1);
            end
          end
        end else if (eof) begin
          push           = 1'b1;
          res_kind       = pfpd_pkg::KIND_ERROR;
          res.error_code = pfpd_pkg::ERR_TRUNCATED;
          phase_next     = PH_DONE;
        end
      end

      default: begin
        // ignore bytes until end of file
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && eof)) begin
      phase           <= PH_HEADER;
      byte_index      <= '0;
      word_shift      <= '0;
      header_length   <= '0;
      stored_width    <= '0;
      stored_height   <= '0;
      stored_channels <= '0;
      dim_zero        <= 1'b0;
      dim_big         <= 1'b0;
      chan_bad        <= 1'b0;
      column_count    <= '0;
      row_count       <= '0;
      channel_index   <= '0;
      pixel_bytes     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      word_shift      <= word_shift_next;
      header_length   <= header_length_next;
      stored_width    <= stored_width_next;
      stored_height   <= stored_height_next;
      stored_channels <= stored_channels_next;
      dim_zero        <= dim_zero_next;
      dim_big         <= dim_big_next;
      chan_bad        <= chan_bad_next;
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      channel_index   <= channel_index_next;
      pixel_bytes     <= pixel_bytes_next;
    end

    // two result slots: out feeds the port, skid catches one result under stall
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_res    <= skid_res;
        out_kind   <= skid_kind;
        out_last   <= skid_last;
        skid_valid <= 1'b0;
      end
    end else if (accept && push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
        out_res   <= res;
        out_kind  <= res_kind;
        out_last  <= res_last;
      end else begin
        skid_valid <= 1'b1;
        skid_res   <= res;
        skid_kind  <= res_kind;
        skid_last  <= res_last;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output slot empty");

  a_eof_rearms: assert property (@(posedge clk) disable iff (rst)
    (accept && eof) |=> (phase == PH_HEADER && byte_index == 32'd0 &&
                         channel_index == 2'd0))
    else $error("parser not rearmed after end of file");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DONE) |-> !push)
    else $error("result produced after error or last pixel");

  a_last_is_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_last) |-> (out_kind == pfpd_pkg::KIND_PIXEL))
    else $error("last flag on a non-pixel result");

endmodule

// ===== verif/tb_pattern_file_pixel_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pattern file pixel decoder - testbench
// Feeds whole pattern files byte by byte: a table of directed files for the
// header checks, the error cases and the size extremes, then random
// files. Most are well formed, the rest are broken or plain noise. Each
// request is decoded by an in-bench parser and every result on the master
// side is compared field by field with the oldest decoded one.
// ----------------------------------------------------------------------------
module tb_pattern_file_pixel_decoder;

  localparam int RandBytes  = 650;
  localparam int StallLimit = 1000;
  localparam int NoCheck    = -1;
  localparam int DirCount   = 26;

  typedef enum logic [1:0] {
    ST_HEADER,
    ST_NAME,
    ST_PIXELS,
    ST_DONE
  } parse_state_t;

  typedef struct packed {
    pfpd_pkg::kind_t   kind;
    logic              last;
    pfpd_pkg::result_t data;
  } decoded_t;

  // len 0 means the nominal length; want overrides the predicted error code
  typedef struct packed {
    bit [31:0] hdr_len;
    bit [31:0] width;
    bit [31:0] height;
    bit [31:0] chans;
    bit [7:0]  name_tail;
    int        len;
    int        want;
  } file_spec_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [7:0]                    s_tdata = '0;
  logic                          s_tlast = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [pfpd_pkg::OutDataW-1:0] m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;

  pattern_file_pixel_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state
  parse_state_t parse_st;
  bit [31:0]    hdr_pos, shift_word, hdr_len, img_w, img_h, img_ch;
  bit [7:0]     name_tail;
  bit [31:0]    col_cnt, row_cnt;
  bit [1:0]     chan_idx;
  bit [23:0]    pix_acc;

  decoded_t decoded_q[$];
  int       mismatches = 0;
  int       bytes_taken = 0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  bit       quiet = 1'b0;

  file_spec_t directed_files [DirCount] = '{
    '{32'd0,  32'd1, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_SHORT_HEADER},
    '{32'd23, 32'd1, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_SHORT_HEADER},
    '{32'd24, 32'd1, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_UNTERMINATED},
    '{32'd25, 32'd1, 32'd1, 32'd1, 8'h80, 0, pfpd_pkg::ERR_UNTERMINATED},
    '{32'd25, 32'd0, 32'd0, 32'd0, 8'hFF, 0, pfpd_pkg::ERR_UNTERMINATED},
    '{32'd25, 32'd0, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_ZERO_SIZE},
    '{32'd30, 32'd1, 32'd0, 32'd1, 8'h00, 0, pfpd_pkg::ERR_ZERO_SIZE},
    '{32'd25, 32'hFFFF_FFFF, 32'd0, 32'd9, 8'h00, 0, pfpd_pkg::ERR_ZERO_SIZE},
    '{32'd25, 32'd4097, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_TOO_LARGE},
    '{32'd25, 32'd1, 32'hFFFF_FFFF, 32'd1, 8'h00, 0, pfpd_pkg::ERR_TOO_LARGE},
    '{32'd25, 32'd1, 32'd1, 32'd0, 8'h00, 0, pfpd_pkg::ERR_BAD_CHANNELS},
    '{32'd25, 32'd1, 32'd1, 32'd5, 8'h00, 0, pfpd_pkg::ERR_BAD_CHANNELS},
    '{32'd25, 32'd1, 32'd1, 32'h8000_0001, 8'h00, 0, pfpd_pkg::ERR_BAD_CHANNELS},
    '{32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1, 8'h00, 0, pfpd_pkg::ERR_SHORT_HEADER},
    '{32'd25, 32'd2, 32'd2, 32'd3, 8'h00, 10, pfpd_pkg::ERR_SHORT_HEADER},
    '{32'd25, 32'd2, 32'd2, 32'd3, 8'h00, 25, pfpd_pkg::ERR_TRUNCATED},
    '{32'd25, 32'd2, 32'd2, 32'd3, 8'h00, 27, pfpd_pkg::ERR_TRUNCATED},
    '{32'd25, 32'd2, 32'd2, 32'd3, 8'h00, 28, pfpd_pkg::ERR_TRUNCATED},
    '{32'd24, 32'd1, 32'd1, 32'd1, 8'h00, 30, pfpd_pkg::ERR_UNTERMINATED},
    '{32'd25, 32'd2, 32'd2, 32'd1, 8'h00, 0, NoCheck},
    '{32'd27, 32'd3, 32'd1, 32'd2, 8'h00, 0, NoCheck},
    '{32'd25, 32'd1, 32'd3, 32'd3, 8'h00, 0, NoCheck},
    '{32'd40, 32'd2, 32'd2, 32'd4, 8'h00, 61, NoCheck},
    '{32'd25, 32'd4096, 32'd4096, 32'd1, 8'h00, 30, NoCheck},
    '{32'd25, 32'd1, 32'd4096, 32'd2, 8'h00, 40, NoCheck},
    '{32'd26, 32'd3, 32'd2, 32'd4, 8'h00, 0, NoCheck}
  };

  function automatic void clear_decoder();
    parse_st   = ST_HEADER;
    hdr_pos    = '0;
    shift_word = '0;
    hdr_len    = '0;
    img_w      = '0;
    img_h      = '0;
    img_ch     = '0;
    name_tail  = '0;
    col_cnt    = '0;
    row_cnt    = '0;
    chan_idx   = '0;
    pix_acc    = '0;
  endfunction

  function automatic bit flag_error(inout decoded_t res, input pfpd_pkg::err_t code);
    res.kind            = pfpd_pkg::KIND_ERROR;
    res.data.error_code = code;
    parse_st            = ST_DONE;
    return 1'b1;
  endfunction

  // advances the parser by one file byte; returns 1 when a result is due
  function automatic bit decode_byte(input logic [7:0] b, input logic eof,
                                     output decoded_t res);
    bit       hit;
    bit       at_end;
    bit [7:0] b0, b1, b2;
    res = '0;
    hit = 1'b0;
    case (parse_st)
      ST_HEADER: begin
        shift_word = {shift_word[23:0], b};
        if (hdr_pos == pfpd_pkg::LenByte) hdr_len = shift_word;
        else if (hdr_pos == pfpd_pkg::WidthByte) img_w = shift_word;
        else if (hdr_pos == pfpd_pkg::HeightByte) img_h = shift_word;
        else if (hdr_pos == pfpd_pkg::ChanByte) img_ch = shift_word;
        if (hdr_pos == pfpd_pkg::HeaderLast) begin
          if (hdr_len < pfpd_pkg::HeaderBytes)
            hit = flag_error(res, pfpd_pkg::ERR_SHORT_HEADER);
          else if (hdr_len == pfpd_pkg::HeaderBytes)
            hit = flag_error(res, pfpd_pkg::ERR_UNTERMINATED);
          else parse_st = ST_NAME;
        end
        hdr_pos++;
        if (eof && !hit) hit = flag_error(res, pfpd_pkg::ERR_SHORT_HEADER);
      end
      ST_NAME: begin
        name_tail = b;
        if (hdr_pos == hdr_len - 32'd1) begin
          if (name_tail != 8'd0)
            hit = flag_error(res, pfpd_pkg::ERR_UNTERMINATED);
          else if (img_w == 0 || img_h == 0)
            hit = flag_error(res, pfpd_pkg::ERR_ZERO_SIZE);
          else if (img_w > pfpd_pkg::MaxDim || img_h > pfpd_pkg::MaxDim)
            hit = flag_error(res, pfpd_pkg::ERR_TOO_LARGE);
          else if (img_ch < 1 || img_ch > 4)
            hit = flag_error(res, pfpd_pkg::ERR_BAD_CHANNELS);
          else if (eof)
            hit = flag_error(res, pfpd_pkg::ERR_TRUNCATED);
          else begin
            res.kind              = pfpd_pkg::KIND_HEADER;
            res.data.channels     = img_ch[2:0];
            res.data.image_width  = img_w[pfpd_pkg::DimW-1:0];
            res.data.image_height = img_h[pfpd_pkg::DimW-1:0];
            hit      = 1'b1;
            parse_st = ST_PIXELS;
            col_cnt  = '0;
            row_cnt  = '0;
            chan_idx = '0;
            pix_acc  = '0;
          end
        end else if (eof) begin
          hit = flag_error(res, pfpd_pkg::ERR_SHORT_HEADER);
        end
        hdr_pos++;
      end
      ST_PIXELS: begin
        if (chan_idx < 3) pix_acc = pix_acc | ({16'd0, b} << (8 * chan_idx));
        chan_idx = chan_idx + 2'd1;
        // four channels wrap the index back to zero
        if (chan_idx == img_ch[1:0]) begin
          b0     = pix_acc[7:0];
          b1     = pix_acc[15:8];
          b2     = pix_acc[23:16];
          at_end = (col_cnt == img_w - 32'd1) && (row_cnt == img_h - 32'd1);
          if (eof && !at_end) begin
            hit = flag_error(res, pfpd_pkg::ERR_TRUNCATED);
          end else begin
            res.kind = pfpd_pkg::KIND_PIXEL;
            case (img_ch)
              1: res.data = '{red: b0, green: b0, blue: b0, alpha: 8'hFF, default: '0};
              2: res.data = '{red: b0, green: b0, blue: b0, alpha: b1, default: '0};
              3: res.data = '{red: b0, green: b1, blue: b2, alpha: 8'hFF, default: '0};
              default: res.data = '{red: b0, green: b1, blue: b2, alpha: b, default: '0};
            endcase
            res.data.column = col_cnt[pfpd_pkg::CoordW-1:0];
            res.data.row    = row_cnt[pfpd_pkg::CoordW-1:0];
            res.last        = at_end;
            hit             = 1'b1;
            if (at_end) begin
              parse_st = ST_DONE;
            end else if (col_cnt == img_w - 32'd1) begin
              col_cnt = '0;
              row_cnt++;
            end else begin
              col_cnt++;
            end
          end
          chan_idx = '0;
          pix_acc  = '0;
        end else if (eof) begin
          hit = flag_error(res, pfpd_pkg::ERR_TRUNCATED);
        end
      end
      default: ;
    endcase
    if (eof) clear_decoder();
    return hit;
  endfunction

  function automatic int nominal_len(file_spec_t f);
    longint name_end;
    longint bpp;
    longint pix;
    // an absurd header size is cut short so the file ends inside the name
    name_end = (f.hdr_len < pfpd_pkg::HeaderBytes) ? pfpd_pkg::HeaderBytes :
               (f.hdr_len > 64 ? 32 : f.hdr_len);
    bpp      = (f.chans >= 1 && f.chans <= 4) ? f.chans : 0;
    pix      = (f.width >= 1 && f.width <= pfpd_pkg::MaxDim &&
                f.height >= 1 && f.height <= pfpd_pkg::MaxDim) ?
               longint'(f.width) * longint'(f.height) * bpp : 0;
    return int'(name_end + pix);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eof, input int want);
    decoded_t res;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_taken++;
    if (decode_byte(b, eof, res)) begin
      if (want != NoCheck && res.kind == pfpd_pkg::KIND_ERROR)
        res.data.error_code = 3'(want);
      decoded_q.push_back(res);
    end
  endtask

  task automatic send_file(input file_spec_t f);
    int          total;
    logic [31:0] version, magic, word;
    logic [7:0]  b;
    total   = (f.len != 0) ? f.len : nominal_len(f);
    version = $urandom;
    magic   = $urandom;
    case ($urandom_range(2))
      0: idle_pct = 0;
      1: idle_pct = 5;
      default: idle_pct = 25;
    endcase
    stall_pct = $urandom_range(2) * 12;
    if (quiet) begin
      idle_pct  = 0;
      stall_pct = 0;
    end
    for (int i = 0; i < total; i++) begin
      if (i < pfpd_pkg::HeaderBytes) begin
        case (i / 4)
          0: word = f.hdr_len;
          1: word = version;
          2: word = f.width;
          3: word = f.height;
          4: word = f.chans;
          default: word = magic;
        endcase
        b = word[8 * (3 - i % 4) +: 8];
      end else if (longint'(i) == longint'(f.hdr_len) - 1) begin
        b = f.name_tail;
      end else begin
        b = $urandom;
      end
      send_byte(b, i == total - 1, f.want);
    end
  endtask

  task automatic compare_field(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // result side: checks, receiver stalls and the watchdog
  initial begin
    decoded_t          want;
    pfpd_pkg::result_t got;
    int                stall_left;
    int                quiet_cycles;
    stall_left   = 0;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result, kind %0d data %0h", $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          compare_field("kind", want.kind, m_tuser);
          compare_field("last_pixel", want.last, m_tlast);
          compare_field("red", want.data.red, got.red);
          compare_field("green", want.data.green, got.green);
          compare_field("blue", want.data.blue, got.blue);
          compare_field("alpha", want.data.alpha, got.alpha);
          compare_field("column", want.data.column, got.column);
          compare_field("row", want.data.row, got.row);
          compare_field("channels", want.data.channels, got.channels);
          compare_field("image_width", want.data.image_width, got.image_width);
          compare_field("image_height", want.data.image_height, got.image_height);
          compare_field("error_code", want.data.error_code, got.error_code);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (stall_left > 0) stall_left--;
      else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        stall_left = $urandom_range(1, 19);
      m_tready <= (stall_left == 0);
    end
    $display("%0t: no request moved for %0d cycles", $time, StallLimit);
    $display("[pattern_file_pixel_decoder] ERROR");
    $finish;
  end

  // request side
  initial begin
    file_spec_t f;
    int         pick;
    int         nominal;
    int         rand_start;
    clear_decoder();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_files[k]) send_file(directed_files[k]);

    rand_start = bytes_taken;
    while (bytes_taken - rand_start < RandBytes) begin
      quiet          = (bytes_taken - rand_start) > RandBytes - 250;
      f              = '{default: 0};
      f.want         = NoCheck;
      f.hdr_len      = pfpd_pkg::HeaderBytes + $urandom_range(1, 6);
      f.width        = $urandom_range(1, 6);
      f.height       = $urandom_range(1, 6);
      f.chans        = $urandom_range(1, 4);
      pick           = $urandom_range(99);
      if (pick < 70) begin
        nominal = nominal_len(f);
        case ($urandom_range(9))
          0: f.len = $urandom_range(1, nominal - 1);
          1: f.len = nominal + $urandom_range(1, 8);
          default: ;
        endcase
      end else if (pick < 90) begin
        case ($urandom_range(4))
          0: f.name_tail = $urandom_range(1, 255);
          1: if ($urandom_range(1)) f.width = 0; else f.height = 0;
          2: if ($urandom_range(1))
               f.width = $urandom_range(32'hFFFF_FFFF, pfpd_pkg::MaxDim + 1);
             else
               f.height = $urandom_range(pfpd_pkg::MaxDim + 8, pfpd_pkg::MaxDim + 1);
          3: f.chans = $urandom_range(1) ? 32'd0 : $urandom_range(32'hFFFF_FFFF, 5);
          default: f.hdr_len = $urandom_range(0, pfpd_pkg::HeaderBytes);
        endcase
      end else begin
        // plain noise
        f.hdr_len   = $urandom_range(1) ? $urandom : $urandom_range(0, 40);
        f.width     = $urandom_range(0, 8);
        f.height    = $urandom_range(0, 8);
        f.chans     = $urandom_range(0, 6);
        f.name_tail = $urandom;
        f.len       = $urandom_range(1, 60);
      end
      send_file(f);
    end
    s_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("[pattern_file_pixel_decoder] OK");
    end else begin
      $display("[pattern_file_pixel_decoder] ERROR");
    end
    $finish;
  end

endmodule
